[sv/dsp_load_file_parser_assert.svh]
// ----------------------------------------------------------------------------
// dsp_load_file_parser_assert.svh
// Assertion macros used by the load-file parser checker.
// ----------------------------------------------------------------------------
`ifndef DSP_LOAD_FILE_PARSER_ASSERT_SVH
`define DSP_LOAD_FILE_PARSER_ASSERT_SVH

// Clocked assertion, disabled while reset is high
`define DLFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define DLFP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/dlfp_pkg.sv]
// ----------------------------------------------------------------------------
// dlfp_pkg
// Types, keyword tables and character helpers for the load-file parser.
// ----------------------------------------------------------------------------
package dlfp_pkg;

  localparam int NUM_KW = 6;
  localparam int DATA_W = 24;

  // Keyword indexes
  localparam logic [2:0] KW_START   = 3'd0;
  localparam logic [2:0] KW_SYMBOL  = 3'd1;
  localparam logic [2:0] KW_END     = 3'd2;
  localparam logic [2:0] KW_DATA    = 3'd3;
  localparam logic [2:0] KW_BDATA   = 3'd4;
  localparam logic [2:0] KW_COMMENT = 3'd5;

  // Load status codes
  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_FATAL = 2'd2;

  // Keyword text, first character in the highest used byte
  localparam logic [79:0] KW_TEXT [NUM_KW] = '{
    80'("_START"), 80'("_SYMBOL"), 80'("_END"),
    80'("_DATA"), 80'("_BLOCKDATA"), 80'("_COMMENT")
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd6, 4'd7, 4'd4, 4'd5, 4'd10, 4'd8};

  // Token scanner state seen by the record logic
  typedef struct packed {
    logic              in_token;
    logic              is_keyword;
    logic [NUM_KW-1:0] candidates;
    logic [3:0]        char_index;
    logic [DATA_W-1:0] hex_acc;
    logic              digit_seen;
  } tok_info_t;

  // Per-transaction control into the token scanner
  typedef struct packed {
    logic step;
    logic eof;
    logic comment_busy;
  } tok_ctl_t;

  // Record engine status toward the top level
  typedef struct packed {
    logic done;
    logic comment_busy;
  } rec_stat_t;

  // One result item
  typedef struct packed {
    logic        write_valid;
    logic [15:0] write_address;
    logic [31:0] write_word;
    logic [1:0]  load_status;
  } result_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // {valid, digit}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") r = {1'b1, 4'(c - 8'h30)};
    else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - 8'h57)};
    else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  // Character idx of keyword k; meaningful only for idx below its length
  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [3:0] idx);
    logic [79:0] txt;
    logic [3:0]  pos;
    txt = KW_TEXT[k];
    pos = KW_LEN[k] - idx - 4'd1;
    return txt[{pos, 3'b000} +: 8];
  endfunction

endpackage

[sv/dlfp_token.sv]
// ----------------------------------------------------------------------------
// dlfp_token
// Token scanner: tracks the open token, keyword match and leading hex value.
// ----------------------------------------------------------------------------
module dlfp_token (
  input  logic                clk,
  input  logic                rst,
  input  dlfp_pkg::tok_ctl_t  ctl,
  input  logic [7:0]          char_code,
  output dlfp_pkg::tok_info_t tok
);
  import dlfp_pkg::*;

  logic              in_token, in_token_next;
  logic              token_is_keyword, token_is_keyword_next;
  logic [NUM_KW-1:0] keyword_candidates, keyword_candidates_next;
  logic [3:0]        keyword_char_index, keyword_char_index_next;
  logic [DATA_W-1:0] hex_accumulator, hex_accumulator_next;
  logic              hex_prefix_open, hex_prefix_open_next;
  logic              hex_digit_seen, hex_digit_seen_next;
  logic [4:0]        hv;

  assign hv = hex_val(char_code);

  // Next token state for one transaction
  always_comb begin
    in_token_next           = in_token;
    token_is_keyword_next   = token_is_keyword;
    keyword_candidates_next = keyword_candidates;
    keyword_char_index_next = keyword_char_index;
    hex_accumulator_next    = hex_accumulator;
    hex_prefix_open_next    = hex_prefix_open;
    hex_digit_seen_next     = hex_digit_seen;
    if (ctl.step) begin
      if (ctl.eof) begin
        in_token_next = 1'b0;
      end else if (ctl.comment_busy) begin
        in_token_next = in_token;
      end else if (is_ws(char_code)) begin
        in_token_next = 1'b0;
      end else begin
        // first character opens a fresh token
        if (!in_token) begin
          in_token_next           = 1'b1;
          token_is_keyword_next   = (char_code == "_");
          keyword_candidates_next = '1;
          keyword_char_index_next = 4'd0;
          hex_accumulator_next    = '0;
          hex_prefix_open_next    = 1'b1;
          hex_digit_seen_next     = 1'b0;
        end
        // drop keywords that no longer match
        for (int k = 0; k < NUM_KW; k++) begin
          if (keyword_char_index_next >= KW_LEN[k] ||
              kw_char(3'(k), keyword_char_index_next) != char_code)
            keyword_candidates_next[k] = 1'b0;
        end
        if (keyword_char_index_next != 4'hF)
          keyword_char_index_next = keyword_char_index_next + 4'd1;
        // leading hex digits
        if (hex_prefix_open_next) begin
          if (hv[4]) begin
            hex_accumulator_next = {hex_accumulator_next[DATA_W-5:0], hv[3:0]};
            hex_digit_seen_next  = 1'b1;
          end else begin
            hex_prefix_open_next = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_token           <= 1'b0;
      token_is_keyword   <= 1'b0;
      keyword_candidates <= '1;
      keyword_char_index <= 4'd0;
      hex_accumulator    <= '0;
      hex_prefix_open    <= 1'b1;
      hex_digit_seen     <= 1'b0;
    end else begin
      in_token           <= in_token_next;
      token_is_keyword   <= token_is_keyword_next;
      keyword_candidates <= keyword_candidates_next;
      keyword_char_index <= keyword_char_index_next;
      hex_accumulator    <= hex_accumulator_next;
      hex_prefix_open    <= hex_prefix_open_next;
      hex_digit_seen     <= hex_digit_seen_next;
    end
  end

  assign tok = '{in_token:   in_token,
                 is_keyword: token_is_keyword,
                 candidates: keyword_candidates,
                 char_index: keyword_char_index,
                 hex_acc:    hex_accumulator,
                 digit_seen: hex_digit_seen};

endmodule

[sv/dlfp_record.sv]
// ----------------------------------------------------------------------------
// dlfp_record
// Record engine: follows the record grammar, emits memory writes and status.
// ----------------------------------------------------------------------------
module dlfp_record #(
  parameter int ADDR_WIDTH = 16,
  parameter int WORD_SHIFT = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                eof,
  input  logic [7:0]          char_code,
  input  dlfp_pkg::tok_info_t tok,
  output dlfp_pkg::rec_stat_t stat,
  output logic                res_valid,
  output dlfp_pkg::result_t   res
);
  import dlfp_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE, M_START, M_DATA, M_BDATA, M_END, M_COMMENT
  } mode_t;

  typedef enum logic [1:0] {
    CP_NONE, CP_WAIT_NL, CP_SKIP
  } cphase_t;

  localparam logic [24:0] FOLD_LIMIT = 25'h8000;

  mode_t                 record_mode, record_mode_next;
  logic [2:0]            field_position, field_position_next;
  cphase_t               comment_phase, comment_phase_next;
  logic [ADDR_WIDTH-1:0] load_address, load_address_next;
  logic [DATA_W-1:0]     last_data_value, last_data_value_next;
  logic [1:0]            finished, finished_next;

  logic        do_close, do_cchar, cchar_after, do_dispatch;
  logic        wv;
  logic [15:0] wa;
  logic [31:0] ww;
  logic [24:0] a_ext;
  logic [2:0]  hit;
  logic        hit_ok;

  // Keyword hit from the surviving candidates
  always_comb begin
    hit    = KW_START;
    hit_ok = 1'b0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (tok.candidates[k] && KW_LEN[k] == tok.char_index) begin
        hit    = 3'(k);
        hit_ok = 1'b1;
      end
    end
  end

  // Next record state for one transaction
  always_comb begin
    record_mode_next     = record_mode;
    field_position_next  = field_position;
    comment_phase_next   = comment_phase;
    load_address_next    = load_address;
    last_data_value_next = last_data_value;
    finished_next        = finished;
    do_close    = 1'b0;
    do_cchar    = 1'b0;
    cchar_after = 1'b0;
    do_dispatch = 1'b0;
    wv    = 1'b0;
    wa    = '0;
    ww    = '0;
    a_ext = 25'(load_address);

    // what this transaction does
    if (step) begin
      if (eof) begin
        do_close = tok.in_token;
      end else if (comment_phase != CP_NONE) begin
        do_cchar = 1'b1;
      end else if (is_ws(char_code) && tok.in_token) begin
        do_close    = 1'b1;
        cchar_after = 1'b1;
      end
    end

    // token close
    if (do_close) begin
      case (record_mode)
        M_START: begin
          field_position_next = field_position + 3'd1;
          if (field_position_next >= 3'd3) begin
            field_position_next = 3'd0;
            comment_phase_next  = CP_WAIT_NL;
          end
        end
        M_BDATA: begin
          field_position_next = field_position + 3'd1;
          if (field_position_next >= 3'd4) begin
            field_position_next = 3'd0;
            record_mode_next    = M_IDLE;
          end
        end
        M_END: begin
          do_dispatch = tok.is_keyword;
        end
        M_DATA: begin
          if (field_position == 3'd0) begin
            field_position_next = 3'd1;
          end else if (field_position == 3'd1) begin
            if (tok.digit_seen) load_address_next = tok.hex_acc[ADDR_WIDTH-1:0];
            field_position_next = 3'd2;
          end else if (tok.is_keyword) begin
            do_dispatch = 1'b1;
          end else begin
            if (tok.digit_seen) last_data_value_next = tok.hex_acc;
            // fold high addresses, then write and advance
            if (a_ext > FOLD_LIMIT) a_ext = a_ext - FOLD_LIMIT;
            wv = 1'b1;
            wa = a_ext[15:0];
            ww = 32'(last_data_value_next) << WORD_SHIFT;
            load_address_next = ADDR_WIDTH'(a_ext + 25'd1);
          end
        end
        default: begin
          if (tok.is_keyword) do_dispatch = 1'b1;
          else finished_next = ST_FATAL;
        end
      endcase
    end

    // keyword starts a record; _SYMBOL finishes the load, an unknown keyword is fatal
    if (do_dispatch) begin
      field_position_next = 3'd0;
      if (!hit_ok) begin
        finished_next = ST_FATAL;
      end else begin
        case (hit)
          KW_START:  record_mode_next = M_START;
          KW_SYMBOL: finished_next    = ST_DONE;
          KW_END:    record_mode_next = M_END;
          KW_DATA:   record_mode_next = M_DATA;
          KW_BDATA:  record_mode_next = M_BDATA;
          KW_COMMENT: begin
            record_mode_next   = M_COMMENT;
            comment_phase_next = CP_WAIT_NL;
          end
          default:   finished_next    = ST_FATAL;
        endcase
      end
    end

    // comment line handling, also for the whitespace that closed a token
    if (do_cchar ||
        (cchar_after && finished_next == ST_RUN && comment_phase_next != CP_NONE)) begin
      if (comment_phase_next == CP_WAIT_NL) begin
        if (char_code == 8'h0A) comment_phase_next = CP_SKIP;
        else if (!is_ws(char_code)) finished_next = ST_DONE;
      end else if (char_code == 8'h0A) begin
        comment_phase_next  = CP_NONE;
        record_mode_next    = M_IDLE;
        field_position_next = 3'd0;
      end
    end

    // end of file finishes a running load
    if (step && eof && finished_next == ST_RUN) finished_next = ST_DONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_mode     <= M_IDLE;
      field_position  <= 3'd0;
      comment_phase   <= CP_NONE;
      load_address    <= '0;
      last_data_value <= '0;
      finished        <= ST_RUN;
    end else if (step) begin
      record_mode     <= record_mode_next;
      field_position  <= field_position_next;
      comment_phase   <= comment_phase_next;
      load_address    <= load_address_next;
      last_data_value <= last_data_value_next;
      finished        <= finished_next;
    end
  end

  assign stat      = '{done: (finished != ST_RUN), comment_busy: (comment_phase != CP_NONE)};
  assign res_valid = step && (wv || finished_next != ST_RUN);
  assign res       = '{write_valid: wv, write_address: wa, write_word: ww,
                       load_status: finished_next};

endmodule

[sv/dlfp_outreg.sv]
// ----------------------------------------------------------------------------
// dlfp_outreg
// Result register on the master side; takes a new result whenever it drains.
// ----------------------------------------------------------------------------
module dlfp_outreg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  dlfp_pkg::result_t res,
  output logic              ready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [55:0]       m_tdata,  // write_address[15:0], write_word[47:16], load_status[49:48]
  output logic              m_tuser   // write_valid
);
  import dlfp_pkg::*;

  result_t held;

  assign ready = !m_tvalid || m_tready;

  // valid flag and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ready) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      held <= res;
    end
  end

  assign m_tdata = {6'b0, held.load_status, held.write_word, held.write_address};
  assign m_tuser = held.write_valid;

endmodule

[sv/dsp_load_file_parser.sv]
// Results are registered; each reaches the master side in the cycle after its character.
// Throughput: 1 character per cycle when not stalled; token and record state update in the
// accept cycle, so each transaction sees the state left by the one before.
// Reset: rst is synchronous and active high; all parser state returns to idle
// at once, no clearing pass. After a finish status, characters are taken silently.
// ----------------------------------------------------------------------------
// dsp_load_file_parser
// Text load-image parser producing DSP memory writes from a character stream.
// ----------------------------------------------------------------------------
module dsp_load_file_parser #(
  parameter int ADDR_WIDTH = 16,
  parameter int WORD_SHIFT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_code[7:0]
  input  logic        s_tlast,   // end_of_file
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // write_address[15:0], write_word[47:16], load_status[49:48]
  output logic        m_tuser    // write_valid
);
  import dlfp_pkg::*;

  tok_info_t tok;
  tok_ctl_t  tctl;
  rec_stat_t rstat;
  result_t   res;
  logic      res_valid;
  logic      out_ready;
  logic      step;

  // a transaction does work only while the load is running
  assign s_tready = out_ready;
  assign step     = s_tvalid && s_tready && !rstat.done;
  assign tctl     = '{step: step, eof: s_tlast, comment_busy: rstat.comment_busy};

  dlfp_token u_token (
    .clk       (clk),
    .rst       (rst),
    .ctl       (tctl),
    .char_code (s_tdata),
    .tok       (tok)
  );

  dlfp_record #(
    .ADDR_WIDTH (ADDR_WIDTH),
    .WORD_SHIFT (WORD_SHIFT)
  ) u_record (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .eof       (s_tlast),
    .char_code (s_tdata),
    .tok       (tok),
    .stat      (rstat),
    .res_valid (res_valid),
    .res       (res)
  );

  dlfp_outreg u_outreg (
    .clk      (clk),
    .rst      (rst),
    .load     (res_valid),
    .res      (res),
    .ready    (out_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

[sv/dlfp_checker.sv]
// ----------------------------------------------------------------------------
// dlfp_checker
// Port-level checks on the parser's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "dsp_load_file_parser_assert.svh"

module dlfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic        m_tuser
);
  import dlfp_pkg::*;

  logic [1:0] status;

  assign status = m_tdata[49:48];

  // a result without a write only reports the end of the load
  `DLFP_ASSERT(a_nowrite_has_status,
    m_tvalid && !m_tuser |-> status != ST_RUN,
    "result with neither write nor finish status")
  // a result without a write carries zero address and data
  `DLFP_ASSERT(a_nowrite_zero,
    m_tvalid && !m_tuser |-> m_tdata[47:0] == 48'd0,
    "non-write result carries address or data")
  // a write never comes with a fatal status, and status 3 never shows
  `DLFP_ASSERT(a_write_not_fatal,
    m_tvalid && m_tuser |-> status == ST_RUN || status == ST_DONE,
    "write reported with fatal or invalid status")
  // stalled result holds
  `DLFP_ASSERT(a_hold,
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser),
    "stalled result changed")
  // no result appears right out of reset without a transaction
  `DLFP_ASSERT_ALWAYS(a_reset_quiet, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind dsp_load_file_parser dlfp_checker u_dlfp_checker (.*);
